>>> src/tcb_pkg.sv
// Shared types and constants for the text cell buffer.
package tcb_pkg;

	typedef enum logic [2:0] {
		OP_MOVE  = 3'd0,
		OP_PUT   = 3'd1,
		OP_READ  = 3'd2,
		OP_CLEAR = 3'd3,
		OP_TOUCH = 3'd4,
		OP_SCAN  = 3'd5
	} tcb_op_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_CLEAR,
		S_TOUCH,
		S_SCAN,
		S_DONE
	} tcb_state_t;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_RANGE = 2'd1;
	localparam logic [1:0] STAT_NONE  = 2'd2;

	localparam logic [2:0] CFG_TOP  = 3'd0;
	localparam logic [2:0] CFG_LEFT = 3'd1;
	localparam logic [2:0] CFG_ROWS = 3'd2;
	localparam logic [2:0] CFG_COLS = 3'd3;
	localparam logic [2:0] CFG_ATTR = 3'd4;

	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] TAB_STEP = 8'd8;
	localparam logic [7:0] TAB_MASK = ~8'd7;

	typedef struct packed {
		logic [4:0] top;
		logic [6:0] left;
		logic [4:0] rows;
		logic [6:0] cols;
		logic [7:0] attr;
		logic [6:0] r_end;
		logic [8:0] c_end;
		logic       empty;
	} tcb_win_t;

	typedef struct packed {
		logic [4:0] row;
		logic [6:0] col;
		logic [1:0] status;
		logic       on_screen;
		logic       store;
	} tcb_cur_t;

endpackage

>>> src/text_cell_buffer_cursor_engine_core.sv
// Top level: text cell buffer with cursor, window and dirty tracking.
// Move, put and read: one item at a time; input stalled until the result is loaded into the output registers.
// Clear: writes a blank to every cell, one cell written per cycle.
// Touch: marks every cell of the clamped window dirty; next dirty: scans the clamped window,
// one dirty-mark memory read per cycle until a marked cell is found.
// Reset: clearing pass over all SCREEN_ROWS*SCREEN_COLS cells (1920 by default), input stalled.
module text_cell_buffer_cursor_engine_core #(
	parameter int SCREEN_ROWS = 24,
	parameter int SCREEN_COLS = 80
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] operation,
	input  logic [4:0] target_row,
	input  logic [6:0] target_col,
	input  logic [7:0] char_code,
	input  logic [7:0] char_attr,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] status,
	output logic [7:0] cell_char,
	output logic [7:0] cell_attr,
	output logic [4:0] cell_row,
	output logic [6:0] cell_col,
	output logic [4:0] cursor_row_out,
	output logic [6:0] cursor_col_out
);
	import tcb_pkg::*;

	localparam int CELLS = SCREEN_ROWS * SCREEN_COLS;
	localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int RW = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
	localparam int CW = $clog2(SCREEN_COLS);

	tcb_win_t   win;
	tcb_cur_t   cur;
	logic [AW-1:0] cur_addr;
	tcb_state_t state_q, state_d;

	logic [4:0]    cur_row_q;
	logic [6:0]    cur_col_q;
	logic [AW-1:0] sw_q;
	logic [RW-1:0] y_q;
	logic [CW-1:0] x_q;
	logic [AW-1:0] base_q;
	logic          issue_done_q;
	logic          chk_v_s1;
	logic [AW-1:0] chk_addr_s1;
	logic [RW-1:0] chk_y_s1;
	logic [CW-1:0] chk_x_s1;

	logic       use_ram_q;
	logic [1:0] res_status_q;
	logic [7:0] res_char_q;
	logic [7:0] res_attr_q;
	logic [4:0] res_row_q;
	logic [6:0] res_col_q;

	logic       out_valid_q;
	logic [1:0] out_status_q;
	logic [7:0] out_char_q;
	logic [7:0] out_attr_q;
	logic [4:0] out_row_q;
	logic [6:0] out_col_q;
	logic [4:0] out_crow_q;
	logic [6:0] out_ccol_q;

	logic          d_we, d_re, m_we, m_re;
	logic [AW-1:0] d_waddr, d_raddr, m_waddr, m_raddr;
	logic [15:0]   d_wdata, d_rdata;
	logic [0:0]    m_wdata, m_rdata;

	logic          in_acc;
	tcb_op_t       op;
	logic [AW-1:0] scan_addr;
	logic          x_last, y_last, win_last, sweep_last;
	logic          hit, out_free, out_load;

	tcb_cfg #(.SCREEN_ROWS(SCREEN_ROWS), .SCREEN_COLS(SCREEN_COLS)) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.win      (win)
	);

	tcb_cursor #(.SCREEN_ROWS(SCREEN_ROWS), .SCREEN_COLS(SCREEN_COLS)) u_cursor (
		.win       (win),
		.operation (operation),
		.target_row(target_row),
		.target_col(target_col),
		.char_code (char_code),
		.cur_row   (cur_row_q),
		.cur_col   (cur_col_q),
		.nxt       (cur),
		.addr      (cur_addr)
	);

	tcb_ram #(.WIDTH(16), .DEPTH(CELLS)) u_data_ram (
		.clk  (clk),
		.we   (d_we),
		.waddr(d_waddr),
		.wdata(d_wdata),
		.re   (d_re),
		.raddr(d_raddr),
		.rdata(d_rdata)
	);

	tcb_ram #(.WIDTH(1), .DEPTH(CELLS)) u_mark_ram (
		.clk  (clk),
		.we   (m_we),
		.waddr(m_waddr),
		.wdata(m_wdata),
		.re   (m_re),
		.raddr(m_raddr),
		.rdata(m_rdata)
	);

	assign cfg_ready  = 1'b1;
	assign in_stall   = (state_q != S_IDLE);
	assign in_acc     = in_valid && !in_stall;
	assign op         = tcb_op_t'(operation);
	assign scan_addr  = base_q + AW'(x_q);
	assign x_last     = (32'(x_q) + 1) == 32'(win.c_end);
	assign y_last     = (32'(y_q) + 1) == 32'(win.r_end);
	assign win_last   = x_last && y_last;
	assign sweep_last = (sw_q == AW'(CELLS - 1));
	assign hit        = (state_q == S_SCAN) && chk_v_s1 && m_rdata[0];
	assign out_free   = !out_valid_q || !out_stall;
	assign out_load   = (state_q == S_DONE) && out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT: begin
				if (sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_acc) begin
					case (op)
						OP_CLEAR: state_d = S_CLEAR;
						OP_TOUCH: state_d = win.empty ? S_DONE : S_TOUCH;
						OP_SCAN:  state_d = win.empty ? S_DONE : S_SCAN;
						default:  state_d = S_DONE;
					endcase
				end
			end
			S_CLEAR: begin
				if (sweep_last) begin
					state_d = S_DONE;
				end
			end
			S_TOUCH: begin
				if (win_last) begin
					state_d = S_DONE;
				end
			end
			S_SCAN: begin
				if (hit || (chk_v_s1 && issue_done_q)) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		d_we    = 1'b0;
		d_waddr = cur_addr;
		d_wdata = {char_attr | win.attr, char_code};
		d_re    = 1'b0;
		d_raddr = cur_addr;
		m_we    = 1'b0;
		m_waddr = cur_addr;
		m_wdata = 1'b1;
		m_re    = 1'b0;
		m_raddr = scan_addr;
		case (state_q)
			S_INIT, S_CLEAR: begin
				d_we    = 1'b1;
				d_waddr = sw_q;
				d_wdata = {8'd0, CH_SPACE};
				m_we    = 1'b1;
				m_waddr = sw_q;
			end
			S_IDLE: begin
				if (in_acc && op == OP_PUT && cur.store) begin
					d_we = 1'b1;
					m_we = 1'b1;
				end
				if (in_acc && op == OP_READ && cur.on_screen) begin
					d_re = 1'b1;
				end
			end
			S_TOUCH: begin
				m_we    = 1'b1;
				m_waddr = scan_addr;
			end
			S_SCAN: begin
				if (hit) begin
					m_we    = 1'b1;
					m_waddr = chk_addr_s1;
					m_wdata = 1'b0;
					d_re    = 1'b1;
					d_raddr = chk_addr_s1;
				end else if (!issue_done_q) begin
					m_re = 1'b1;
				end
			end
			S_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			cur_row_q    <= 5'd0;
			cur_col_q    <= 7'd0;
			sw_q         <= '0;
			issue_done_q <= 1'b0;
			chk_v_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				cur_row_q    <= cur.row;
				cur_col_q    <= cur.col;
				sw_q         <= '0;
				issue_done_q <= 1'b0;
				chk_v_s1     <= 1'b0;
			end
			if (state_q == S_INIT || state_q == S_CLEAR) begin
				sw_q <= sw_q + AW'(1);
			end
			if (state_q == S_SCAN) begin
				chk_v_s1 <= !issue_done_q && !hit;
				if (!issue_done_q && !hit && win_last) begin
					issue_done_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			y_q          <= RW'(win.top);
			x_q          <= CW'(win.left);
			base_q       <= AW'(32'(win.top) * SCREEN_COLS);
			use_ram_q    <= (op == OP_READ) && cur.on_screen;
			res_status_q <= cur.status;
			res_char_q   <= (op == OP_READ && !cur.on_screen) ? CH_SPACE : 8'd0;
			res_attr_q   <= 8'd0;
			res_row_q    <= 5'd0;
			res_col_q    <= 7'd0;
		end
		if (state_q == S_TOUCH || (state_q == S_SCAN && !issue_done_q && !hit)) begin
			if (x_last) begin
				x_q    <= CW'(win.left);
				y_q    <= y_q + RW'(1);
				base_q <= base_q + AW'(SCREEN_COLS);
			end else begin
				x_q <= x_q + CW'(1);
			end
		end
		if (state_q == S_SCAN) begin
			chk_addr_s1 <= scan_addr;
			chk_y_s1    <= y_q;
			chk_x_s1    <= x_q;
			if (hit) begin
				use_ram_q <= 1'b1;
				res_row_q <= 5'(chk_y_s1);
				res_col_q <= 7'(chk_x_s1);
			end else if (chk_v_s1 && issue_done_q) begin
				res_status_q <= STAT_NONE;
			end
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_char_q   <= use_ram_q ? d_rdata[7:0] : res_char_q;
			out_attr_q   <= use_ram_q ? d_rdata[15:8] : res_attr_q;
			out_row_q    <= res_row_q;
			out_col_q    <= res_col_q;
			out_crow_q   <= cur_row_q;
			out_ccol_q   <= cur_col_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign cell_char      = out_char_q;
	assign cell_attr      = out_attr_q;
	assign cell_row       = out_row_q;
	assign cell_col       = out_col_q;
	assign cursor_row_out = out_crow_q;
	assign cursor_col_out = out_ccol_q;

endmodule

>>> src/tcb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/tcb_cfg.sv
// Window configuration registers and window clamping.
module tcb_cfg #(
	parameter int SCREEN_ROWS = 24,
	parameter int SCREEN_COLS = 80
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [2:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	output tcb_pkg::tcb_win_t win
);
	import tcb_pkg::*;

	logic [4:0] top_q;
	logic [6:0] left_q;
	logic [4:0] rows_q;
	logic [6:0] cols_q;
	logic [7:0] attr_q;
	logic [5:0] r_bound;
	logic [7:0] c_bound;
	logic [6:0] r_end;
	logic [8:0] c_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q  <= 5'd0;
			left_q <= 7'd0;
			rows_q <= 5'd24;
			cols_q <= 7'd80;
			attr_q <= 8'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TOP:  top_q  <= cfg_data[4:0];
				CFG_LEFT: left_q <= cfg_data[6:0];
				CFG_ROWS: rows_q <= cfg_data[4:0];
				CFG_COLS: cols_q <= cfg_data[6:0];
				CFG_ATTR: attr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		r_bound = 6'(top_q) + 6'(rows_q);
		c_bound = 8'(left_q) + 8'(cols_q);
		r_end = (32'(r_bound) > SCREEN_ROWS) ? 7'(SCREEN_ROWS) : 7'(r_bound);
		c_end = (32'(c_bound) > SCREEN_COLS) ? 9'(SCREEN_COLS) : 9'(c_bound);
		win.top   = top_q;
		win.left  = left_q;
		win.rows  = rows_q;
		win.cols  = cols_q;
		win.attr  = attr_q;
		win.r_end = r_end;
		win.c_end = c_end;
		win.empty = (7'(top_q) >= r_end) || (9'(left_q) >= c_end);
	end

endmodule

>>> src/tcb_cursor.sv
// Cursor update, screen position and cell address for single-cell operations.
module tcb_cursor #(
	parameter int SCREEN_ROWS = 24,
	parameter int SCREEN_COLS = 80,
	localparam int CELLS = SCREEN_ROWS * SCREEN_COLS,
	localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1
) (
	input  tcb_pkg::tcb_win_t win,
	input  logic [2:0]        operation,
	input  logic [4:0]        target_row,
	input  logic [6:0]        target_col,
	input  logic [7:0]        char_code,
	input  logic [4:0]        cur_row,
	input  logic [6:0]        cur_col,
	output tcb_pkg::tcb_cur_t nxt,
	output logic [AW-1:0]     addr
);
	import tcb_pkg::*;

	logic [5:0] sy;
	logic [7:0] sx;
	logic       on_screen;
	logic [4:0] nl_row;
	logic [7:0] tab_col;
	logic [7:0] inc_col;

	always_comb begin
		sy = 6'(cur_row) + 6'(win.top);
		sx = 8'(cur_col) + 8'(win.left);
		on_screen = (32'(sy) < SCREEN_ROWS) && (32'(sx) < SCREEN_COLS);
		addr = AW'(32'(sy) * SCREEN_COLS + 32'(sx));
		nl_row = ((6'(cur_row) + 6'd1) < 6'(win.rows)) ? cur_row + 5'd1 : cur_row;
		tab_col = (8'(cur_col) + TAB_STEP) & TAB_MASK;
		inc_col = 8'(cur_col) + 8'd1;

		nxt.row = cur_row;
		nxt.col = cur_col;
		nxt.status = STAT_OK;
		nxt.on_screen = on_screen;
		nxt.store = 1'b0;

		case (tcb_op_t'(operation))
			OP_MOVE: begin
				if (target_row < win.rows && target_col < win.cols) begin
					nxt.row = target_row;
					nxt.col = target_col;
				end else begin
					nxt.status = STAT_RANGE;
				end
			end
			OP_PUT: begin
				if (!on_screen) begin
					nxt.status = STAT_RANGE;
				end else begin
					case (char_code)
						CH_NL: begin
							nxt.row = nl_row;
							nxt.col = 7'd0;
						end
						CH_CR: nxt.col = 7'd0;
						CH_TAB: begin
							if (tab_col >= 8'(win.cols)) begin
								nxt.row = nl_row;
								nxt.col = 7'd0;
							end else begin
								nxt.col = tab_col[6:0];
							end
						end
						default: begin
							nxt.store = 1'b1;
							if (inc_col >= 8'(win.cols)) begin
								nxt.row = nl_row;
								nxt.col = 7'd0;
							end else begin
								nxt.col = inc_col[6:0];
							end
						end
					endcase
				end
			end
			OP_READ: begin
				if (!on_screen) begin
					nxt.status = STAT_RANGE;
				end
			end
			OP_CLEAR: begin
				nxt.row = 5'd0;
				nxt.col = 7'd0;
			end
			OP_TOUCH: ;
			OP_SCAN: begin
				if (win.empty) begin
					nxt.status = STAT_NONE;
				end
			end
			default: nxt.status = STAT_RANGE;
		endcase
	end

endmodule
